// File: rtl/pacr_pkg.sv
`timescale 1ns / 1ps

package pacr_pkg;

    // Port field widths
    localparam int VX_WIDTH     = 16;
    localparam int VTOTAL_WIDTH = 11;
    localparam int AREA_WIDTH   = 42;

    // Internal sizing
    localparam int COORD_WIDTH   = 16;
    localparam int MAX_VERTICES  = 1024;
    localparam int ACC_WIDTH     = 44;
    localparam int CNT_WIDTH     = $clog2(MAX_VERTICES + 1);
    localparam int RECT_VERTICES = 4;
    localparam int MIN_VERTICES  = 3;

    typedef logic signed [COORD_WIDTH-1:0]   t_coord;
    typedef logic signed [COORD_WIDTH:0]     t_diff;
    typedef logic signed [2*COORD_WIDTH-1:0] t_prod;
    typedef logic signed [2*COORD_WIDTH+1:0] t_dprod;
    typedef logic signed [2*COORD_WIDTH+2:0] t_dsum;
    typedef logic signed [ACC_WIDTH-1:0]     t_acc;
    typedef logic [CNT_WIDTH-1:0]            t_count;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

endpackage

// File: rtl/pacr_if.sv
`timescale 1ns / 1ps

interface pacr_vtx_if
    import pacr_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic signed [VX_WIDTH-1:0] vx;
    logic signed [VX_WIDTH-1:0] vy;
    logic                       last_vertex;

    modport source (output valid, vx, vy, last_vertex, input ready);
    modport sink   (input valid, vx, vy, last_vertex, output ready);
endinterface

interface pacr_res_if
    import pacr_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [AREA_WIDTH-1:0]   double_area;
    logic [VTOTAL_WIDTH-1:0] vertex_total;
    logic                    is_rectangle;
    logic                    too_few;

    modport source (output valid, double_area, vertex_total, is_rectangle, too_few,
                    input ready);
    modport sink   (input valid, double_area, vertex_total, is_rectangle, too_few,
                    output ready);
endinterface

// File: rtl/polygon_area_and_rectangle_check_unit.sv
`timescale 1ns / 1ps

// Polygon area / rectangle check. Vertices stream in one per beat on i_vtx,
// with last_vertex set on the final one; that beat closes the polygon and one
// result beat follows on o_res with twice the area (exact |shoelace sum|,
// saturated at 2^42-1), the vertex count (saturating at 1024), a rectangle flag
// (exactly four vertices, all corners right angles) and a too-few flag (fewer
// than three vertices). Non-final vertices produce no result. One vertex is
// taken every cycle unless the input is stalled (see below); the result passes
// through the four-stage pipeline (capture and differences, multipliers,
// accumulator, magnitude). While a result waits on a stalled output, non-final
// vertices keep draining into the accumulator; the input stalls only once the
// next final vertex has reached the accumulator stage with two more vertices
// queued behind it.
module polygon_area_and_rectangle_check_unit
    import pacr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pacr_vtx_if.sink   i_vtx,
    pacr_res_if.source o_res
);

    // Pipeline enables, bubbles collapse stage by stage
    logic en1, en2, en3, en4;
    logic accept;

    // Sequencing state
    t_count r_seen;
    t_point r_first, r_prev, r_prev2;

    // Stage 1
    logic   r1_valid, r1_last, r1_step_en, r1_test_a;
    t_count r1_total;
    t_point r1_cur, r1_prev, r1_first;
    t_diff  r1_adx1, r1_ady1, r1_adx2, r1_ady2, r1_bdx2, r1_bdy2;

    // Stage 2
    logic   r2_valid, r2_last, r2_step_en, r2_test_a;
    t_count r2_total;
    t_prod  r2_p1, r2_p2, r2_p3, r2_p4;
    t_dprod r2_d1, r2_d2, r2_d3, r2_d4;

    // Stage 3
    t_acc   r_acc;
    logic   r_angles_ok;
    logic   r3_valid, r3_rect, r3_few;
    t_acc   r3_sum;
    t_count r3_total;

    // Output
    logic                  r_out_valid, r_out_rect, r_out_few;
    logic [AREA_WIDTH-1:0] r_out_area;
    t_count                r_out_total;

    assign en4    = !r_out_valid || o_res.ready;
    assign en3    = !r3_valid || en4;
    assign en2    = !r2_valid || en3;
    assign en1    = !r1_valid || en2;
    assign accept = i_vtx.valid && en1;
    assign i_vtx.ready = en1;

    // ---------------- stage 1: capture, sequencing, differences ----------------
    t_point cur, first_eff, angle_a;
    t_count n_total;

    always_comb begin
        cur.x     = t_coord'(i_vtx.vx[COORD_WIDTH-1:0]);
        cur.y     = t_coord'(i_vtx.vy[COORD_WIDTH-1:0]);
        first_eff = (r_seen == '0) ? cur : r_first;
        // corner at the previous vertex: from first at index 2, from prev2 at index 3
        angle_a   = (r_seen == t_count'(RECT_VERTICES - 2)) ? r_first : r_prev2;
        n_total   = (r_seen < t_count'(MAX_VERTICES)) ? r_seen + 1'b1
                                                      : t_count'(MAX_VERTICES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_first <= '0;
            r_prev  <= '0;
            r_prev2 <= '0;
        end else if (accept) begin
            if (i_vtx.last_vertex) begin
                r_seen  <= '0;
                r_first <= '0;
                r_prev  <= '0;
                r_prev2 <= '0;
            end else begin
                r_seen  <= n_total;
                r_first <= first_eff;
                r_prev  <= cur;
                r_prev2 <= r_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= i_vtx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_last    <= i_vtx.last_vertex;
            r1_step_en <= (r_seen != '0);
            r1_test_a  <= (r_seen == t_count'(RECT_VERTICES - 2)) ||
                          (r_seen == t_count'(RECT_VERTICES - 1));
            r1_total   <= n_total;
            r1_cur     <= cur;
            r1_prev    <= r_prev;
            r1_first   <= first_eff;
            r1_adx1    <= t_diff'(r_prev.x) - t_diff'(angle_a.x);
            r1_ady1    <= t_diff'(r_prev.y) - t_diff'(angle_a.y);
            r1_adx2    <= t_diff'(r_prev.x) - t_diff'(cur.x);
            r1_ady2    <= t_diff'(r_prev.y) - t_diff'(cur.y);
            r1_bdx2    <= t_diff'(cur.x) - t_diff'(first_eff.x);
            r1_bdy2    <= t_diff'(cur.y) - t_diff'(first_eff.y);
        end
    end

    // ---------------- stage 2: products ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r1_valid) begin
            r2_last    <= r1_last;
            r2_step_en <= r1_step_en;
            r2_test_a  <= r1_test_a;
            r2_total   <= r1_total;
            r2_p1      <= r1_prev.x * r1_cur.y;
            r2_p2      <= r1_prev.y * r1_cur.x;
            r2_p3      <= r1_cur.x * r1_first.y;
            r2_p4      <= r1_cur.y * r1_first.x;
            r2_d1      <= r1_adx1 * r1_adx2;
            r2_d2      <= r1_ady1 * r1_ady2;
            // closing corner at the last vertex; its first leg is the negated
            // (prev - cur) leg, which does not change a zero test
            r2_d3      <= r1_adx2 * r1_bdx2;
            r2_d4      <= r1_ady2 * r1_bdy2;
        end
    end

    // ---------------- stage 3: accumulate, angle tests ----------------
    t_acc  step_term, close_term, n_acc;
    t_dsum dot_a, dot_b;
    logic  is_rect_count, n_angles_ok;

    always_comb begin
        step_term     = r2_step_en ? t_acc'(r2_p1) - t_acc'(r2_p2) : '0;
        close_term    = r2_last ? t_acc'(r2_p3) - t_acc'(r2_p4) : '0;
        n_acc         = r_acc + step_term + close_term;
        dot_a         = t_dsum'(r2_d1) + t_dsum'(r2_d2);
        dot_b         = t_dsum'(r2_d3) + t_dsum'(r2_d4);
        is_rect_count = (r2_total == t_count'(RECT_VERTICES));
        n_angles_ok   = r_angles_ok &&
                        !(r2_test_a && (dot_a != '0)) &&
                        !(r2_last && is_rect_count && (dot_b != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_angles_ok <= 1'b1;
            r3_valid    <= 1'b0;
        end else if (en3) begin
            r3_valid <= r2_valid && r2_last;
            if (r2_valid) begin
                if (r2_last) begin
                    r_acc       <= '0;
                    r_angles_ok <= 1'b1;
                end else begin
                    r_acc       <= n_acc;
                    r_angles_ok <= n_angles_ok;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid && r2_last) begin
            r3_sum   <= n_acc;
            r3_total <= r2_total;
            r3_rect  <= is_rect_count && n_angles_ok;
            r3_few   <= (r2_total < t_count'(MIN_VERTICES));
        end
    end

    // ---------------- stage 4: magnitude and saturation ----------------
    logic [ACC_WIDTH-1:0] mag;

    always_comb begin
        mag = r3_sum[ACC_WIDTH-1] ? ACC_WIDTH'(-r3_sum) : ACC_WIDTH'(r3_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en4) begin
            r_out_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r3_valid) begin
            r_out_area  <= (mag[ACC_WIDTH-1:AREA_WIDTH] != '0) ? '1
                                                              : mag[AREA_WIDTH-1:0];
            r_out_total <= r3_total;
            r_out_rect  <= r3_rect;
            r_out_few   <= r3_few;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.double_area  = r_out_area;
    assign o_res.vertex_total = VTOTAL_WIDTH'(r_out_total);
    assign o_res.is_rectangle = r_out_rect;
    assign o_res.too_few      = r_out_few;

`ifndef SYNTHESIS
    a_stall_only_on_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en1 |-> (r1_valid && r2_valid && r3_valid && r_out_valid && !o_res.ready))
        else $error("input stalled without a full pipeline");

    a_last_restarts_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_vtx.last_vertex) |=> (r_seen == '0))
        else $error("vertex count not cleared after closing vertex");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_vtx.last_vertex && (r_seen < t_count'(MAX_VERTICES)))
        |=> (r_seen == $past(r_seen) + 1'b1))
        else $error("vertex count did not advance");

    a_rect_needs_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_rect) |->
        (r_out_total == t_count'(RECT_VERTICES)) && !r_out_few)
        else $error("rectangle flag without four vertices");

    a_accum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en3 && r2_valid && r2_last) |=> (r_acc == '0) && r_angles_ok)
        else $error("accumulator not cleared after polygon");
`endif

endmodule
